// ===== rtl/dnsqp_pkg.sv =====
// ----------------------------------------------------------------------------
// DNS query parser package
// Shared widths, word types, status codes and the default name buffer size.
// ----------------------------------------------------------------------------
package dnsqp_pkg;

  // Default size of the name buffer; it sets the label budget of a packet.
  localparam int unsigned NAME_BUFFER_DEF = 513;

  // Field widths of the words.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned WordW   = 16;
  localparam int unsigned LengthW = 10;

  // Verdict status codes.
  localparam logic [StatusW-1:0] ST_OK     = 3'd0;
  localparam logic [StatusW-1:0] ST_TRUNC  = 3'd1;
  localparam logic [StatusW-1:0] ST_HEADER = 3'd2;
  localparam logic [StatusW-1:0] ST_LONG   = 3'd3;
  localparam logic [StatusW-1:0] ST_CLASS  = 3'd4;

  // Separator between labels in the emitted name.
  localparam logic [ByteW-1:0] DOT_CHAR = 8'h2E;

  // One input word as held in the input register.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             first_of_packet;
    logic             last_of_packet;
  } in_word_t;

  // One result word: a name character or a verdict.
  typedef struct packed {
    logic               is_verdict;
    logic [ByteW-1:0]   name_char;
    logic [StatusW-1:0] status;
    logic [WordW-1:0]   query_type;
    logic [WordW-1:0]   query_id;
    logic [LengthW-1:0] name_length;
  } out_word_t;

endpackage

// ===== rtl/dnsqp_in_if.sv =====
// ----------------------------------------------------------------------------
// DNS query parser input channel
// Valid/ready channel that carries one packet byte per word.
// ----------------------------------------------------------------------------
interface dnsqp_in_if
  import dnsqp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;
  logic             first_of_packet;
  logic             last_of_packet;

  modport source (output valid, output data_byte, output first_of_packet,
                  output last_of_packet, input ready);
  modport sink   (input valid, input data_byte, input first_of_packet,
                  input last_of_packet, output ready);
endinterface

// ===== rtl/dnsqp_out_if.sv =====
// ----------------------------------------------------------------------------
// DNS query parser output channel
// Valid/ready channel that carries name characters and packet verdicts.
// ----------------------------------------------------------------------------
interface dnsqp_out_if
  import dnsqp_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               is_verdict;
  logic [ByteW-1:0]   name_char;
  logic [StatusW-1:0] status;
  logic [WordW-1:0]   query_type;
  logic [WordW-1:0]   query_id;
  logic [LengthW-1:0] name_length;

  modport source (output valid, output is_verdict, output name_char, output status,
                  output query_type, output query_id, output name_length,
                  input ready);
  modport sink   (input valid, input is_verdict, input name_char, input status,
                  input query_type, input query_id, input name_length,
                  output ready);
endinterface

// ===== rtl/dnsqp_parser.sv =====
// ----------------------------------------------------------------------------
// DNS query parser core
// Input register, parse state and the combinational parse step for one byte.
// ----------------------------------------------------------------------------
module dnsqp_parser
  import dnsqp_pkg::*;
#(
  parameter int unsigned NAME_BUFFER = NAME_BUFFER_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_word_i,
  input  logic      res_space_i,
  output logic      res_valid_o,
  output out_word_t res_word_o
);

  localparam int unsigned BudgetW = $clog2(NAME_BUFFER + 1);
  localparam int unsigned CmpW    = (BudgetW > ByteW) ? BudgetW : ByteW;
  localparam logic [BudgetW-1:0] BudgetInit = BudgetW'(NAME_BUFFER);

  // Parse phases.
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_LABEL  = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_FOOTER = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;
  localparam logic [2:0] PH_FAIL   = 3'd6;

  // Input register.
  logic     s1_valid_q;
  in_word_t s1_word_q;
  logic     s1_fire;

  // Parse state.
  logic [2:0]         phase_q, phase_d;
  logic [3:0]         fcount_q, fcount_d;
  logic [ByteW-1:0]   label_left_q, label_left_d;
  logic [BudgetW-1:0] budget_q, budget_d;
  logic [LengthW-1:0] name_count_q, name_count_d;
  logic               seen_label_q, seen_label_d;
  logic [WordW-1:0]   id_q, id_d;
  logic [WordW-1:0]   type_q, type_d;
  logic [WordW-1:0]   class_q, class_d;
  logic [StatusW-1:0] err_q, err_d;

  // Step values after a possible restart on the first byte.
  logic [2:0]         ph_c;
  logic [3:0]         fc_c;
  logic [ByteW-1:0]   ll_c;
  logic [BudgetW-1:0] bud_c;
  logic [LengthW-1:0] nc_c;
  logic               sl_c;
  logic [WordW-1:0]   id_c, ty_c, cl_c;
  logic [StatusW-1:0] er_c;
  logic [ByteW-1:0]   b;
  logic               emit;
  logic [ByteW-1:0]   ch;
  logic [StatusW-1:0] st;
  logic [3:0]         fc_inc;
  logic [CmpW-1:0]    b_ext, bud_ext;
  logic               expect_one;

  assign s1_fire    = s1_valid_q && res_space_i;
  assign in_ready_o = !s1_valid_q || res_space_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_word_q <= in_word_i;
    end
  end

  // Parse step for the byte in the input register.
  always_comb begin
    b = s1_word_q.data_byte;
    if (s1_word_q.first_of_packet) begin
      ph_c  = PH_HEADER;
      fc_c  = '0;
      ll_c  = '0;
      bud_c = BudgetInit;
      nc_c  = '0;
      sl_c  = 1'b0;
      id_c  = '0;
      ty_c  = '0;
      cl_c  = '0;
      er_c  = ST_OK;
    end else begin
      ph_c  = phase_q;
      fc_c  = fcount_q;
      ll_c  = label_left_q;
      bud_c = budget_q;
      nc_c  = name_count_q;
      sl_c  = seen_label_q;
      id_c  = id_q;
      ty_c  = type_q;
      cl_c  = class_q;
      er_c  = err_q;
    end

    phase_d      = ph_c;
    fcount_d     = fc_c;
    label_left_d = ll_c;
    budget_d     = bud_c;
    seen_label_d = sl_c;
    id_d         = id_c;
    type_d       = ty_c;
    class_d      = cl_c;
    err_d        = er_c;
    emit         = 1'b0;
    ch           = '0;
    fc_inc       = fc_c + 4'd1;
    b_ext        = CmpW'(b);
    bud_ext      = CmpW'(bud_c);
    expect_one   = (fc_c == 4'd2) || (fc_c == 4'd5);

    unique case (ph_c)
      PH_HEADER: begin
        if (fc_c < 4'd2) begin
          id_d = {id_c[ByteW-1:0], b};
        end else if (b != {7'd0, expect_one}) begin
          err_d = ST_HEADER;
        end
        fcount_d = fc_inc;
        if (fc_inc == 4'd12) begin
          fcount_d = '0;
          phase_d  = ((err_d != ST_OK) ? PH_FAIL : PH_LEN);
        end
      end
      PH_LEN: begin
        if (b == '0) begin
          phase_d  = PH_FOOTER;
          fcount_d = '0;
        end else if (b_ext >= bud_ext) begin
          err_d        = ST_LONG;
          label_left_d = b;
          phase_d      = PH_SKIP;
        end else begin
          budget_d     = BudgetW'(bud_ext - b_ext - CmpW'(1));
          label_left_d = b;
          phase_d      = PH_LABEL;
          emit         = sl_c;
          ch           = DOT_CHAR;
          seen_label_d = 1'b1;
        end
      end
      PH_LABEL: begin
        emit         = 1'b1;
        ch           = b;
        label_left_d = ll_c - 8'd1;
        if (label_left_d == '0) begin
          phase_d = PH_LEN;
        end
      end
      PH_SKIP: begin
        label_left_d = ll_c - 8'd1;
        if (label_left_d == '0) begin
          phase_d = PH_FAIL;
        end
      end
      PH_FOOTER: begin
        if (fc_c < 4'd2) begin
          type_d = {ty_c[ByteW-1:0], b};
        end else begin
          class_d = {cl_c[ByteW-1:0], b};
        end
        fcount_d = fc_inc;
        if (fc_inc == 4'd4) begin
          if (class_d == 16'd1) begin
            phase_d = PH_DONE;
          end else begin
            err_d   = ST_CLASS;
            phase_d = PH_FAIL;
          end
        end
      end
      default: begin
      end
    endcase

    name_count_d = emit ? (nc_c + 10'd1) : nc_c;

    // Verdict status from the phase reached by this byte.
    if (phase_d == PH_DONE) begin
      st = ST_OK;
    end else if (phase_d == PH_FAIL) begin
      st = err_d;
    end else begin
      st = ST_TRUNC;
    end

    // Result word: a verdict on the last byte, otherwise a name character.
    res_word_o = '0;
    if (s1_word_q.last_of_packet) begin
      res_word_o.is_verdict = 1'b1;
      res_word_o.status     = st;
      if (st == ST_OK) begin
        res_word_o.query_type  = type_d;
        res_word_o.query_id    = id_d;
        res_word_o.name_length = name_count_d;
      end
    end else begin
      res_word_o.name_char = ch;
    end
    res_valid_o = s1_fire && (s1_word_q.last_of_packet || emit);
  end

  // State update; the last byte of a packet returns everything to reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_HEADER;
      fcount_q     <= '0;
      label_left_q <= '0;
      budget_q     <= BudgetInit;
      name_count_q <= '0;
      seen_label_q <= 1'b0;
      id_q         <= '0;
      type_q       <= '0;
      class_q      <= '0;
      err_q        <= ST_OK;
    end else if (s1_fire) begin
      if (s1_word_q.last_of_packet) begin
        phase_q      <= PH_HEADER;
        fcount_q     <= '0;
        label_left_q <= '0;
        budget_q     <= BudgetInit;
        name_count_q <= '0;
        seen_label_q <= 1'b0;
        id_q         <= '0;
        type_q       <= '0;
        class_q      <= '0;
        err_q        <= ST_OK;
      end else begin
        phase_q      <= phase_d;
        fcount_q     <= fcount_d;
        label_left_q <= label_left_d;
        budget_q     <= budget_d;
        name_count_q <= name_count_d;
        seen_label_q <= seen_label_d;
        id_q         <= id_d;
        type_q       <= type_d;
        class_q      <= class_d;
        err_q        <= err_d;
      end
    end
  end

endmodule

// ===== rtl/dnsqp_out_buf.sv =====
// ----------------------------------------------------------------------------
// DNS query parser result buffer
// Two-entry result register with skid slot between the parse step and output.
// ----------------------------------------------------------------------------
module dnsqp_out_buf
  import dnsqp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  out_word_t push_word_i,
  output logic      space_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  out_word_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       pop;

  assign out_valid_o = (count_q != 2'd0);
  assign out_word_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign space_o     = (count_q != 2'd2) || pop;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop};
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

endmodule

// ===== rtl/dns_query_parser.sv =====
// ----------------------------------------------------------------------------
// DNS query parser
// Checks a DNS query header, emits the question name and gives a verdict.
// ----------------------------------------------------------------------------
// Packet bytes enter at one word per clock while input ready is high. The
// accepting edge loads a byte into the input register, and the parse step
// handles it in the cycle that follows. Once the result buffer has space, the
// byte leaves the input register and its result word (a name character, or the
// verdict on the last byte) is pushed into the two-entry result buffer, which
// registers it for the output. While the buffer has space, the block sustains
// one input word every cycle. When the output stalls, the buffer takes up to two
// more result words and the input register holds one more byte before input
// ready drops. Header bytes, the first label length, the name terminator and the
// type and class bytes leave nothing on the output unless they end the packet.
// After a verdict the parser starts a fresh packet.
module dns_query_parser
  import dnsqp_pkg::*;
#(
  parameter int unsigned NAME_BUFFER = NAME_BUFFER_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  dnsqp_in_if.sink    in_i,
  dnsqp_out_if.source out_o
);

  in_word_t  in_word;
  out_word_t res_word;
  out_word_t out_word;
  logic      res_valid;
  logic      res_space;

  assign in_word.data_byte       = in_i.data_byte;
  assign in_word.first_of_packet = in_i.first_of_packet;
  assign in_word.last_of_packet  = in_i.last_of_packet;

  // Parse step with its input register.
  dnsqp_parser #(
    .NAME_BUFFER(NAME_BUFFER)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_word_i   (in_word),
    .res_space_i (res_space),
    .res_valid_o (res_valid),
    .res_word_o  (res_word)
  );

  // Result buffer.
  dnsqp_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_word_i (res_word),
    .space_o     (res_space),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_word_o  (out_word)
  );

  assign out_o.is_verdict  = out_word.is_verdict;
  assign out_o.name_char   = out_word.name_char;
  assign out_o.status      = out_word.status;
  assign out_o.query_type  = out_word.query_type;
  assign out_o.query_id    = out_word.query_id;
  assign out_o.name_length = out_word.name_length;

  // A failed verdict carries no type, id or length.
  a_fail_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.is_verdict && (out_o.status != ST_OK)) |->
    ((out_o.query_type == '0) && (out_o.query_id == '0) && (out_o.name_length == '0)))
    else $error("failed verdict carries nonzero fields");

  // A name character word carries an ok status and no verdict fields.
  a_char_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.is_verdict) |->
    ((out_o.status == ST_OK) && (out_o.query_type == '0) && (out_o.query_id == '0)))
    else $error("name character word carries verdict fields");

  // A verdict word never carries a name character.
  a_verdict_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.is_verdict) |-> (out_o.name_char == '0))
    else $error("verdict word carries a name character");

  // Status codes stay within the defined set.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.status <= ST_CLASS))
    else $error("undefined status code");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS query parser testbench
// Sends directed and random query packets into the parser one word at a time.
// It predicts every name character and verdict, checks the output words in
// order, and varies the input gaps and the output stalls throughout the run.
// ----------------------------------------------------------------------------
module tb;
  import dnsqp_pkg::*;

  localparam int unsigned CyclesLimit = 400_000;
  localparam int unsigned TailCycles  = 16;
  localparam int unsigned RandomBytes = 1250;
  localparam int unsigned HoldStart   = 1200;
  localparam int unsigned HoldLength  = 300;

  // Parse phases of the predicted parser.
  typedef enum logic [2:0] {
    PH_HEADER, PH_LEN, PH_LABEL, PH_SKIP, PH_FOOTER, PH_DONE, PH_FAIL
  } parse_phase_e;

  // Stall patterns of the result receiver.
  typedef enum logic [1:0] {
    RX_ALWAYS, RX_MOSTLY, RX_EVERY_THIRD, RX_SELDOM
  } rx_mode_e;

  // One queued packet byte; wait_drain holds it back until all results are in.
  typedef struct {
    in_word_t word;
    bit       wait_drain;
  } packet_byte_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b1;

  dnsqp_in_if  in_ch ();
  dnsqp_out_if out_ch ();

  dns_query_parser dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  // Packet bytes waiting to be sent and the packet under construction.
  packet_byte_t pending_bytes[$];
  logic [7:0]   pkt[$];
  int           queued_bytes;

  // Predicted parser state and the result words it is due to give.
  parse_phase_e       ph;
  logic [3:0]         field_cnt;
  logic [7:0]         label_left;
  logic [12:0]        budget_left;
  logic [15:0]        char_count;
  logic               label_seen;
  logic [15:0]        id_acc;
  logic [15:0]        qtype_acc;
  logic [15:0]        qclass_acc;
  logic [StatusW-1:0] fault;
  out_word_t          parser_words_q[$];

  // Run statistics.
  int mismatches;
  int bytes_accepted;
  int input_stalls;
  int chars_checked;
  int verdict_tally[0:4];

  // Sender and receiver pacing.
  int          burst_left;
  int          gap_left;
  rx_mode_e    rx_mode;
  int          rx_mode_left;
  int          rx_tick;
  int unsigned hold_cycles;
  int unsigned hold_left;
  int unsigned run_cycles;
  out_word_t   want;
  packet_byte_t next_byte;

  task automatic clear_parse_state();
    ph          = PH_HEADER;
    field_cnt   = '0;
    label_left  = '0;
    budget_left = 13'(NAME_BUFFER_DEF);
    char_count  = '0;
    label_seen  = 1'b0;
    id_acc      = '0;
    qtype_acc   = '0;
    qclass_acc  = '0;
    fault       = ST_OK;
  endtask

  // Advance the predicted parser by one accepted byte and queue its result.
  task automatic parse_byte(input in_word_t w);
    logic               emit;
    logic [7:0]         ch;
    logic [StatusW-1:0] st;
    out_word_t          res;
    emit = 1'b0;
    ch   = '0;
    if (w.first_of_packet) clear_parse_state();
    case (ph)
      PH_HEADER: begin
        if (field_cnt < 2) begin
          id_acc = {id_acc[7:0], w.data_byte};
        end else if (w.data_byte != ((field_cnt == 2 || field_cnt == 5) ? 8'd1 : 8'd0)) begin
          fault = ST_HEADER;
        end
        field_cnt = field_cnt + 4'd1;
        if (field_cnt == 12) begin
          field_cnt = '0;
          ph = (fault != ST_OK) ? PH_FAIL : PH_LEN;
        end
      end
      PH_LEN: begin
        if (w.data_byte == 8'd0) begin
          ph = PH_FOOTER;
          field_cnt = '0;
        end else if (w.data_byte >= budget_left) begin
          fault = ST_LONG;
          label_left = w.data_byte;
          ph = PH_SKIP;
        end else begin
          budget_left = budget_left - w.data_byte - 13'd1;
          label_left = w.data_byte;
          ph = PH_LABEL;
          if (label_seen) begin
            emit = 1'b1;
            ch = DOT_CHAR;
          end
          label_seen = 1'b1;
        end
      end
      PH_LABEL: begin
        emit = 1'b1;
        ch = w.data_byte;
        label_left = label_left - 8'd1;
        if (label_left == 0) ph = PH_LEN;
      end
      PH_SKIP: begin
        label_left = label_left - 8'd1;
        if (label_left == 0) ph = PH_FAIL;
      end
      PH_FOOTER: begin
        if (field_cnt < 2) qtype_acc = {qtype_acc[7:0], w.data_byte};
        else qclass_acc = {qclass_acc[7:0], w.data_byte};
        field_cnt = field_cnt + 4'd1;
        if (field_cnt == 4) begin
          if (qclass_acc == 16'd1) begin
            ph = PH_DONE;
          end else begin
            fault = ST_CLASS;
            ph = PH_FAIL;
          end
        end
      end
      default: ;
    endcase
    if (emit) char_count = char_count + 16'd1;

    res = '0;
    if (w.last_of_packet) begin
      if (ph == PH_DONE) st = ST_OK;
      else if (ph == PH_FAIL) st = fault;
      else st = ST_TRUNC;
      res.is_verdict = 1'b1;
      res.status     = st;
      if (st == ST_OK) begin
        res.query_type  = qtype_acc;
        res.query_id    = id_acc;
        res.name_length = char_count[LengthW-1:0];
      end
      parser_words_q.push_back(res);
      clear_parse_state();
    end else if (emit) begin
      res.name_char = ch;
      parser_words_q.push_back(res);
    end
  endtask

  function automatic void check_field(input string fname, input logic [15:0] exp_val,
                                      input logic [15:0] got_val);
    if (got_val !== exp_val) begin
      $error("%s: expected 0x%0h, got 0x%0h", fname, exp_val, got_val);
      mismatches++;
    end
  endfunction

  // Header with the given id, standard query flags and one question.
  task automatic start_query(input logic [15:0] id);
    pkt.delete();
    pkt.push_back(id[15:8]);
    pkt.push_back(id[7:0]);
    pkt.push_back(8'h01);
    pkt.push_back(8'h00);
    pkt.push_back(8'h00);
    pkt.push_back(8'h01);
    repeat (6) pkt.push_back(8'h00);
  endtask

  task automatic add_label(input int len);
    pkt.push_back(8'(len));
    repeat (len) pkt.push_back(8'($urandom_range(0, 255)));
  endtask

  // Name terminator, then query type and class.
  task automatic end_question(input logic [15:0] qtype, input logic [15:0] qclass);
    pkt.push_back(8'h00);
    pkt.push_back(qtype[15:8]);
    pkt.push_back(qtype[7:0]);
    pkt.push_back(qclass[15:8]);
    pkt.push_back(qclass[7:0]);
  endtask

  task automatic send_packet(input bit mark_first, input bit mark_last, input bit wait_drain);
    packet_byte_t pb;
    foreach (pkt[i]) begin
      pb.word.data_byte       = pkt[i];
      pb.word.first_of_packet = mark_first && (i == 0);
      pb.word.last_of_packet  = mark_last && (i == pkt.size() - 1);
      pb.wait_drain           = wait_drain && (i == 0);
      pending_bytes.push_back(pb);
    end
    queued_bytes += pkt.size();
  endtask

  // Clock.
  initial begin
    forever #1 clk = ~clk;
  end

  // Stimulus, reset and end of run.
  initial begin
    int           random_start;
    int           kind;
    int           pos;
    bit           force_first;
    logic [15:0]  rnd_class;
    packet_byte_t pb;

    rst_n <= 1'b0;

    // Root name with the largest id and type.
    start_query(16'hFFFF);
    end_question(16'hFFFF, 16'h0001);
    send_packet(1'b1, 1'b1, 1'b0);
    // Two labels, smallest id and type, trailing bytes ignored.
    start_query(16'h0000);
    add_label(1);
    add_label(63);
    end_question(16'h0000, 16'h0001);
    pkt.push_back(8'hFF);
    pkt.push_back(8'h00);
    send_packet(1'b1, 1'b1, 1'b0);
    // A packet of one byte, marked first and last.
    pkt.delete();
    pkt.push_back(8'hA5);
    send_packet(1'b1, 1'b1, 1'b0);
    // Bad flags in a complete packet.
    start_query(16'h1234);
    pkt[3] = 8'h80;
    add_label(3);
    end_question(16'h0001, 16'h0001);
    send_packet(1'b1, 1'b1, 1'b0);
    // Bad answer count, but the packet ends inside the header: truncation wins.
    start_query(16'h4321);
    pkt[7] = 8'hFF;
    pkt = pkt[0:8];
    send_packet(1'b1, 1'b1, 1'b0);
    // Header only, ending on its last byte.
    start_query(16'h7E81);
    send_packet(1'b1, 1'b1, 1'b0);
    // Wrong classes.
    start_query(16'h0102);
    add_label(4);
    end_question(16'h001C, 16'h0100);
    send_packet(1'b1, 1'b1, 1'b0);
    start_query(16'h0203);
    add_label(2);
    end_question(16'h0005, 16'h0000);
    send_packet(1'b1, 1'b1, 1'b0);
    // Last byte falls inside a label.
    start_query(16'h3C3C);
    add_label(5);
    add_label(6);
    pkt = pkt[0:21];
    send_packet(1'b1, 1'b1, 1'b0);
    // Last byte is the name terminator.
    start_query(16'h6006);
    add_label(2);
    pkt.push_back(8'h00);
    send_packet(1'b1, 1'b1, 1'b0);
    // A packet cut off without a last mark, then a restart that first waits
    // until every pending result has come out.
    start_query(16'hC3C3);
    add_label(7);
    send_packet(1'b1, 1'b0, 1'b0);
    start_query(16'hBEEF);
    add_label(2);
    end_question(16'h0001, 16'h0001);
    send_packet(1'b1, 1'b1, 1'b1);
    // A new packet after a verdict without the first mark.
    start_query(16'h0F0F);
    add_label(3);
    end_question(16'h000F, 16'h0001);
    send_packet(1'b0, 1'b1, 1'b0);
    // Longest name: the last label is one below the remaining budget.
    start_query(16'h5A5A);
    add_label(255);
    add_label(254);
    add_label(1);
    end_question(16'h0010, 16'h0001);
    send_packet(1'b1, 1'b1, 1'b0);
    // Compression pointer byte read as a length, then a label equal to the
    // remaining budget, which is rejected.
    start_query(16'hA0A0);
    add_label(192);
    add_label(255);
    add_label(64);
    end_question(16'h0001, 16'h0001);
    send_packet(1'b1, 1'b1, 1'b0);
    // Rejected label, but the packet ends while its bytes are skipped.
    start_query(16'h0A0A);
    add_label(255);
    add_label(255);
    add_label(5);
    pkt = pkt[0:pkt.size() - 3];
    send_packet(1'b1, 1'b1, 1'b0);

    // Random packets: mostly well formed, the rest faulty, cut short or noise.
    random_start = queued_bytes;
    force_first = 1'b1;
    while (queued_bytes - random_start < RandomBytes) begin
      kind = $urandom_range(0, 99);
      start_query(16'($urandom));
      repeat ($urandom_range(0, 4)) begin
        add_label(($urandom_range(0, 7) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 12));
      end
      if (kind >= 60 && kind < 70) begin
        pos = $urandom_range(2, 11);
        pkt[pos] = pkt[pos] ^ 8'($urandom_range(1, 255));
      end
      rnd_class = 16'h0001;
      if (kind >= 70 && kind < 78) begin
        do rnd_class = 16'($urandom); while (rnd_class == 16'h0001);
      end
      end_question(16'($urandom), rnd_class);
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
      end
      if (kind >= 78 && kind < 94) pkt = pkt[0:$urandom_range(0, pkt.size() - 2)];

      if (kind >= 88 && kind < 94) begin
        // Cut off with no last mark; the next packet must restart the parser.
        send_packet(1'b1, 1'b0, 1'b0);
        force_first = 1'b1;
      end else if (kind >= 94) begin
        // Loose bytes with random marks.
        repeat ($urandom_range(1, 8)) begin
          pb.word.data_byte       = 8'($urandom);
          pb.word.first_of_packet = ($urandom_range(0, 3) == 0);
          pb.word.last_of_packet  = ($urandom_range(0, 3) == 0);
          pb.wait_drain           = 1'b0;
          pending_bytes.push_back(pb);
          queued_bytes++;
        end
        force_first = 1'b1;
      end else begin
        send_packet(force_first || ($urandom_range(0, 9) != 0), 1'b1, 1'b0);
        force_first = 1'b0;
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Wait until every byte is taken and every result has arrived.
    while (pending_bytes.size() != 0 || in_ch.valid || parser_words_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TailCycles) @(posedge clk);

    $display("Parsed %0d bytes with %0d cycles of input back-pressure; checked %0d name characters.",
             bytes_accepted, input_stalls, chars_checked);
    $display("Verdicts ok/truncated/bad header/name too long/bad class: %0d/%0d/%0d/%0d/%0d.",
             verdict_tally[0], verdict_tally[1], verdict_tally[2], verdict_tally[3],
             verdict_tally[4]);
    if (mismatches == 0) begin
      $display("dns_query_parser: match");
    end else begin
      $display("dns_query_parser: mismatch");
    end
    $finish;
  end

  // Input driver: bursts of words separated by random gaps.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_ch.valid           <= 1'b0;
      in_ch.data_byte       <= '0;
      in_ch.first_of_packet <= 1'b0;
      in_ch.last_of_packet  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
      clear_parse_state();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        parse_byte({in_ch.data_byte, in_ch.first_of_packet, in_ch.last_of_packet});
        bytes_accepted++;
        if (burst_left > 0) burst_left--;
      end else if (in_ch.valid) begin
        input_stalls++;
      end

      // A word is held until it is taken; otherwise pick the next one.
      if (!in_ch.valid || in_ch.ready) begin
        if (burst_left == 0) begin
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                   : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                   : $urandom_range(0, 4);
        end
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_bytes.size() != 0 &&
                     !(pending_bytes[0].wait_drain && parser_words_q.size() != 0)) begin
          next_byte = pending_bytes.pop_front();
          in_ch.valid           <= 1'b1;
          in_ch.data_byte       <= next_byte.word.data_byte;
          in_ch.first_of_packet <= next_byte.word.first_of_packet;
          in_ch.last_of_packet  <= next_byte.word.last_of_packet;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the input side backs up.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      hold_cycles <= 0;
      hold_left   <= 0;
    end else begin
      hold_cycles <= hold_cycles + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (hold_cycles == HoldStart || $urandom_range(0, 5999) == 0) begin
        hold_left <= HoldLength;
      end
    end
  end

  // Output monitor: checks each result word and sets the stall pattern.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_mode      = RX_ALWAYS;
      rx_mode_left = 0;
      rx_tick      = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (parser_words_q.size() == 0) begin
          $error("unexpected result word: is_verdict %0d name_char 0x%0h status %0d",
                 out_ch.is_verdict, out_ch.name_char, out_ch.status);
          mismatches++;
        end else begin
          want = parser_words_q.pop_front();
          check_field("is_verdict", 16'(want.is_verdict), 16'(out_ch.is_verdict));
          check_field("name_char", 16'(want.name_char), 16'(out_ch.name_char));
          check_field("status", 16'(want.status), 16'(out_ch.status));
          check_field("query_type", want.query_type, out_ch.query_type);
          check_field("query_id", want.query_id, out_ch.query_id);
          check_field("name_length", 16'(want.name_length), 16'(out_ch.name_length));
          if (want.is_verdict) verdict_tally[want.status]++;
          else chars_checked++;
        end
      end

      // Switch the stall pattern now and then, including stretches with none.
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(32, 400);
      end else begin
        rx_mode_left--;
      end
      rx_tick++;
      case (rx_mode)
        RX_ALWAYS:      out_ch.ready <= (hold_left == 0);
        RX_MOSTLY:      out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 9) < 7);
        RX_EVERY_THIRD: out_ch.ready <= (hold_left == 0) && (rx_tick % 3 == 0);
        default:        out_ch.ready <= (hold_left == 0) && ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    run_cycles <= run_cycles + 1;
    if (run_cycles == CyclesLimit) begin
      $display("Timed out with %0d bytes unsent and %0d results outstanding.",
               pending_bytes.size(), parser_words_q.size());
      $display("dns_query_parser: mismatch");
      $finish;
    end
  end

  initial run_cycles = 0;

endmodule

// ===== sim.f =====
rtl/dnsqp_pkg.sv
rtl/dnsqp_in_if.sv
rtl/dnsqp_out_if.sv
rtl/dnsqp_parser.sv
rtl/dnsqp_out_buf.sv
rtl/dns_query_parser.sv
dv/tb.sv
